>>> sv/fcma_pkg.sv
// ----------------------------------------------------------------------------
// fcma_pkg
// Shared types and constants for the five-channel moving average filter.
// ----------------------------------------------------------------------------
package fcma_pkg;

  localparam int NUM_CH     = 5;
  localparam int STAMP_W    = 32;
  localparam int WLEN_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

  localparam logic              RST_FILTER_ENABLE = 1'b1;
  localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH = 7'd8;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_LOAD,
    BK_STEP,
    BK_OUT
  } back_state_e;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic bypass;
  } head_t;

endpackage

>>> sv/fcma_front.sv
// ----------------------------------------------------------------------------
// fcma_front
// Accepts input requests, tags them as averaged or bypassed and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fcma_front #(
  parameter int SampleBits = 16,
  parameter int TdataW     = 112,
  localparam int PayW      = fcma_pkg::NUM_CH * SampleBits + fcma_pkg::STAMP_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,
  input  logic              enable_i,
  input  logic              pop_i,
  output fcma_pkg::head_t   head_o,
  output logic [PayW-1:0]   head_data_o
);

  logic [PayW:0] ent_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // bit PayW marks a bypass request (filter disabled when accepted)
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= {~enable_i, s_axis_tdata[PayW-1:0]};
    end
  end

  assign head_o.valid  = (cnt_q != 2'd0);
  assign head_o.bypass = ent_q[rd_q][PayW];
  assign head_data_o   = ent_q[rd_q][PayW-1:0];

endmodule

>>> sv/fcma_back.sv
// ----------------------------------------------------------------------------
// fcma_back
// History memory, running sums and a shared restoring divider that turns
// each channel sum into a mean, plus the output register.
// ----------------------------------------------------------------------------
module fcma_back #(
  parameter int SampleBits = 16,
  parameter int MaxWindow  = 64,
  parameter int TdataW     = 112,
  localparam int PayW      = fcma_pkg::NUM_CH * SampleBits + fcma_pkg::STAMP_W,
  localparam int WinW      = $clog2(MaxWindow + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcma_pkg::head_t   head_i,
  input  logic [PayW-1:0]   head_data_i,
  output logic              pop_o,
  input  logic              clear_i,
  input  logic [WinW-1:0]   win_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata
);

  localparam int NumCh = fcma_pkg::NUM_CH;
  localparam int LogW  = $clog2(MaxWindow);
  localparam int SumW  = SampleBits + LogW;
  localparam int PtrW  = LogW;
  localparam int MemW  = NumCh * SampleBits;
  localparam int BitW  = $clog2(SampleBits);
  localparam int StW   = fcma_pkg::STAMP_W;

  fcma_pkg::back_state_e state_q, state_d;

  logic [MemW-1:0]       hist_mem [MaxWindow];
  logic [MemW-1:0]       old_q;
  logic                  rd_en, wr_en;
  logic [PtrW-1:0]       slot;

  logic [SampleBits-1:0] smp_q [NumCh];
  logic [SampleBits-1:0] smp_d [NumCh];
  logic [StW-1:0]        stamp_q, stamp_d;
  logic [PtrW-1:0]       slot_q, slot_d;
  logic [SumW-1:0]       sums_q [NumCh];
  logic [SumW-1:0]       sums_d [NumCh];
  logic [WinW-1:0]       fill_q, fill_d;
  logic [PtrW-1:0]       wptr_q, wptr_d;
  logic [2:0]            ch_q, ch_d;
  logic [BitW-1:0]       bit_q, bit_d;
  logic [WinW-1:0]       rem_q, rem_d;
  logic [SampleBits-1:0] dvd_q, dvd_d;
  logic [SampleBits-1:0] res_q [NumCh];
  logic [SampleBits-1:0] res_d [NumCh];
  logic                  m_valid_q, m_valid_d;
  logic [TdataW-1:0]     m_data_q, m_data_d;

  logic [MemW-1:0]       new_row;
  logic [WinW:0]         shifted, trial;
  logic                  ge;
  logic [PayW-1:0]       pay;
  logic [WinW-1:0]       slot_inc;

  assign slot     = (WinW'(wptr_q) >= win_i) ? '0 : wptr_q;
  assign slot_inc = WinW'(slot_q) + WinW'(1);
  assign shifted  = {rem_q, dvd_q[SampleBits-1]};
  assign trial    = shifted - {1'b0, fill_q};
  assign ge       = (shifted >= {1'b0, fill_q});

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      new_row[c*SampleBits +: SampleBits] = smp_q[c];
      pay[c*SampleBits +: SampleBits]     = res_q[c];
    end
    pay[MemW +: StW] = stamp_q;
  end

  always_comb begin
    state_d   = state_q;
    stamp_d   = stamp_q;
    slot_d    = slot_q;
    fill_d    = fill_q;
    wptr_d    = wptr_q;
    ch_d      = ch_q;
    bit_d     = bit_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    for (int c = 0; c < NumCh; c++) begin
      smp_d[c]  = smp_q[c];
      sums_d[c] = sums_q[c];
      res_d[c]  = res_q[c];
    end

    unique case (state_q)
      fcma_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          stamp_d = head_data_i[MemW +: StW];
          for (int c = 0; c < NumCh; c++) begin
            smp_d[c] = head_data_i[c*SampleBits +: SampleBits];
            res_d[c] = head_data_i[c*SampleBits +: SampleBits];
          end
          if (head_i.bypass) begin
            state_d = fcma_pkg::BK_OUT;
          end else begin
            slot_d  = slot;
            rd_en   = 1'b1;
            state_d = fcma_pkg::BK_UPDATE;
          end
        end
      end
      fcma_pkg::BK_UPDATE: begin
        wr_en = 1'b1;
        for (int c = 0; c < NumCh; c++) begin
          if (fill_q >= win_i) begin
            sums_d[c] = sums_q[c] - SumW'(old_q[c*SampleBits +: SampleBits])
                        + SumW'(smp_q[c]);
          end else begin
            sums_d[c] = sums_q[c] + SumW'(smp_q[c]);
          end
        end
        if (fill_q < win_i) begin
          fill_d = fill_q + WinW'(1);
        end
        wptr_d  = (slot_inc >= win_i) ? '0 : PtrW'(slot_inc);
        ch_d    = '0;
        state_d = fcma_pkg::BK_LOAD;
      end
      fcma_pkg::BK_LOAD: begin
        // upper sum bits are always below the divisor
        rem_d   = WinW'(sums_q[ch_q][SumW-1:SampleBits]);
        dvd_d   = sums_q[ch_q][SampleBits-1:0];
        bit_d   = BitW'(SampleBits - 1);
        state_d = fcma_pkg::BK_STEP;
      end
      fcma_pkg::BK_STEP: begin
        rem_d = ge ? trial[WinW-1:0] : shifted[WinW-1:0];
        dvd_d = {dvd_q[SampleBits-2:0], ge};
        bit_d = bit_q - BitW'(1);
        if (bit_q == '0) begin
          res_d[ch_q] = {dvd_q[SampleBits-2:0], ge};
          if (ch_q == 3'(NumCh - 1)) begin
            state_d = fcma_pkg::BK_OUT;
          end else begin
            ch_d    = ch_q + 3'd1;
            state_d = fcma_pkg::BK_LOAD;
          end
        end
      end
      fcma_pkg::BK_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = TdataW'(pay);
          state_d   = fcma_pkg::BK_IDLE;
        end
      end
      default: state_d = fcma_pkg::BK_IDLE;
    endcase

    if (clear_i) begin
      fill_d = '0;
      wptr_d = '0;
      for (int c = 0; c < NumCh; c++) begin
        sums_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcma_pkg::BK_IDLE;
      fill_q    <= '0;
      wptr_q    <= '0;
      ch_q      <= '0;
      bit_q     <= '0;
      m_valid_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        sums_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      wptr_q    <= wptr_d;
      ch_q      <= ch_d;
      bit_q     <= bit_d;
      m_valid_q <= m_valid_d;
      for (int c = 0; c < NumCh; c++) begin
        sums_q[c] <= sums_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q  <= stamp_d;
    slot_q   <= slot_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    m_data_q <= m_data_d;
    for (int c = 0; c < NumCh; c++) begin
      smp_q[c] <= smp_d[c];
      res_q[c] <= res_d[c];
    end
  end

  // old row read per averaged request, used only once the window is full
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      old_q <= hist_mem[slot];
    end
    if (wr_en) begin
      hist_mem[slot_q] <= new_row;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> sv/five_channel_moving_average.sv
// Averaged requests pass through the shared divider, one quotient bit per cycle,
//   channel by channel; bypassed requests skip the divider and go to the output.
// The back end handles one request at a time; a two-entry queue takes new
//   requests while the back end divides or the output waits.
// Reset: filter enabled, window 8, history empty; no clearing pass needed.
// ----------------------------------------------------------------------------
// five_channel_moving_average
// Five-channel simple moving average over ultrasonic distance samples with
// timestamp pass-through and a bypass mode.
// ----------------------------------------------------------------------------
module five_channel_moving_average #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16,
  localparam int TdataW =
    ((fcma_pkg::NUM_CH * SAMPLE_BITS + fcma_pkg::STAMP_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // side_left, side_right, rear_left, rear_center, rear_right samples, stamp_in
  input  logic [TdataW-1:0]               s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // side_left, side_right, rear_left, rear_center, rear_right means, stamp_out
  output logic [TdataW-1:0]               m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [fcma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcma_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int WinW = $clog2(MAX_WINDOW + 1);
  localparam int PayW = fcma_pkg::NUM_CH * SAMPLE_BITS + fcma_pkg::STAMP_W;

  logic                        en_q, en_d;
  logic [fcma_pkg::WLEN_W-1:0] wl_q, wl_d;
  logic                        clear;
  logic [WinW-1:0]             win;
  fcma_pkg::head_t             head;
  logic [PayW-1:0]             head_data;
  logic                        pop;

  always_comb begin
    en_d  = en_q;
    wl_d  = wl_q;
    clear = 1'b0;
    if (cfg_we_i) begin
      if (cfg_idx_i == fcma_pkg::CFG_FILTER_ENABLE) begin
        en_d = cfg_data_i[0];
      end else if (cfg_idx_i == fcma_pkg::CFG_WINDOW_LENGTH) begin
        wl_d  = cfg_data_i[fcma_pkg::WLEN_W-1:0];
        clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= fcma_pkg::RST_FILTER_ENABLE;
      wl_q <= fcma_pkg::RST_WINDOW_LENGTH;
    end else begin
      en_q <= en_d;
      wl_q <= wl_d;
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (wl_q == '0) begin
      win = WinW'(1);
    end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
      win = WinW'(MAX_WINDOW);
    end else begin
      win = WinW'(wl_q);
    end
  end

  fcma_front #(
    .SampleBits (SAMPLE_BITS),
    .TdataW     (TdataW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .enable_i      (en_q),
    .pop_i         (pop),
    .head_o        (head),
    .head_data_o   (head_data)
  );

  fcma_back #(
    .SampleBits (SAMPLE_BITS),
    .MaxWindow  (MAX_WINDOW),
    .TdataW     (TdataW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_data_i   (head_data),
    .pop_o         (pop),
    .clear_i       (clear),
    .win_i         (win),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-channel moving average. A scoreboard
// class keeps its own copy of the per-channel history and running sums and
// predicts every output request from the accepted input requests. Stimulus
// runs a short directed pass over the edge cases, then random phases with
// fresh filter settings, bursty input traffic, a stalling output side and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------

class moving_average_sb;

  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = fcma_pkg::NUM_CH * SAMPLE_W + fcma_pkg::STAMP_W;
  localparam int DEPTH    = 64;

  logic [SAMPLE_W-1:0]       history [DEPTH][fcma_pkg::NUM_CH];
  logic [21:0]               sums [fcma_pkg::NUM_CH];
  int unsigned               fill;
  int unsigned               wptr;
  logic                      filter_on;
  logic [fcma_pkg::WLEN_W-1:0] wlen;
  logic [DATA_W-1:0]         expected_means [$];
  int unsigned               mismatches;

  function new();
    clear_history();
    filter_on  = fcma_pkg::RST_FILTER_ENABLE;
    wlen       = fcma_pkg::RST_WINDOW_LENGTH;
    mismatches = 0;
  endfunction

  function void clear_history();
    foreach (history[i, c]) history[i][c] = '0;
    foreach (sums[c]) sums[c] = '0;
    fill = 0;
    wptr = 0;
  endfunction

  function void note_config(logic [fcma_pkg::CFG_IDX_W-1:0] idx,
                            logic [fcma_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      fcma_pkg::CFG_FILTER_ENABLE: begin
        filter_on = data[0];
      end
      fcma_pkg::CFG_WINDOW_LENGTH: begin
        wlen = data;
        clear_history();
      end
      default: begin
      end
    endcase
  endfunction

  function logic [DATA_W-1:0] predict_means(logic [DATA_W-1:0] req);
    logic [DATA_W-1:0]   res;
    logic [SAMPLE_W-1:0] sample;
    int unsigned         win;
    int unsigned         slot;
    res = req;
    if (filter_on) begin
      // zero acts as one, anything past the store depth saturates
      win = (wlen == 0) ? 1 : ((wlen > DEPTH) ? DEPTH : int'(wlen));
      slot = (wptr >= win) ? 0 : wptr;
      for (int c = 0; c < fcma_pkg::NUM_CH; c++) begin
        sample = req[c*SAMPLE_W +: SAMPLE_W];
        if (fill >= win) sums[c] = sums[c] - history[slot][c];
        history[slot][c] = sample;
        sums[c] = sums[c] + sample;
      end
      if (fill < win) fill++;
      wptr = (slot + 1 >= win) ? 0 : slot + 1;
      for (int c = 0; c < fcma_pkg::NUM_CH; c++)
        res[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(int'(sums[c]) / int'(fill));
    end
    return res;
  endfunction

  function void note_request(logic [DATA_W-1:0] req);
    expected_means = {expected_means, predict_means(req)};
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task check_result(logic [DATA_W-1:0] got);
    string             names [6];
    logic [DATA_W-1:0] want;
    logic [31:0]       g;
    logic [31:0]       w;
    names = '{"side_left_mean", "side_right_mean", "rear_left_mean",
              "rear_center_mean", "rear_right_mean", "stamp_out"};
    if (expected_means.size() == 0) begin
      report_mismatch("unexpected request", got[31:0], '0);
      return;
    end
    want = expected_means[0];
    expected_means.delete(0);
    for (int f = 0; f <= fcma_pkg::NUM_CH; f++) begin
      if (f < fcma_pkg::NUM_CH) begin
        g = 32'(got[f*SAMPLE_W +: SAMPLE_W]);
        w = 32'(want[f*SAMPLE_W +: SAMPLE_W]);
      end else begin
        g = got[fcma_pkg::NUM_CH*SAMPLE_W +: fcma_pkg::STAMP_W];
        w = want[fcma_pkg::NUM_CH*SAMPLE_W +: fcma_pkg::STAMP_W];
      end
      if (g !== w) report_mismatch(names[f], g, w);
    end
  endtask

endclass

module tb_top;

  import fcma_pkg::*;

  localparam int TDATA_W      = 112;
  localparam int HALF_PERIOD  = 6;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 100;

  // indexes past the register list, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  moving_average_sb sb = new();

  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  five_channel_moving_average #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [TDATA_W-1:0] payload);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = payload;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(payload);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (sb.expected_means.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    sb.note_config(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [TDATA_W-1:0] make_request(int unsigned style);
    logic [TDATA_W-1:0] req;
    for (int c = 0; c < NUM_CH; c++) begin
      case (style)
        0: req[c*16 +: 16] = 16'($urandom());
        1: req[c*16 +: 16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        2: req[c*16 +: 16] = 16'($urandom_range(16'hFF00, 16'hFFFF));
        default: req[c*16 +: 16] = 16'($urandom_range(0, 15));
      endcase
    end
    if (style == 1)
      req[80 +: 32] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    else
      req[80 +: 32] = $urandom();
    return req;
  endfunction

  // output side: changing stall styles, plus one long hold-off on request
  initial begin
    int unsigned style;
    int unsigned stretch;
    int unsigned tick;
    int unsigned stall_len;
    stretch = 0;
    tick = 0;
    style = 0;
    stall_len = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (stretch == 0) begin
          style = $urandom_range(0, 3);
          stretch = $urandom_range(50, 300);
          stall_len = $urandom_range(1, 30);
        end
        stretch--;
        tick++;
        case (style)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = tick[0];
          2: m_axis_tready = ($urandom_range(0, 3) != 0);
          default: m_axis_tready = ((tick % 40) >= stall_len);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned count;
    int unsigned win;
    int unsigned style;
    logic        enable;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: averaging on, window of eight, filled and then wrapped
    send_request({32'h0, {5{16'h0000}}});
    send_request({32'hFFFF_FFFF, {5{16'hFFFF}}});
    send_request({32'hAAAA_5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    send_request({32'h5555_AAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    repeat (6) send_request(make_request(0));

    // bypass leaves the history alone, averaging then resumes from it
    wait_idle();
    write_register(CFG_FILTER_ENABLE, 7'd0);
    send_request({32'h0000_0001, {5{16'hFFFF}}});
    send_request({32'h8000_0000, {5{16'h0001}}});
    wait_idle();
    write_register(CFG_FILTER_ENABLE, 7'd1);
    send_request(make_request(0));

    // spare indexes change nothing
    wait_idle();
    write_register(CFG_SPARE_A, 7'h7F);
    write_register(CFG_SPARE_B, 7'h00);
    send_request(make_request(0));

    // window of one, zero treated as one, oversize saturated, two at full scale
    wait_idle();
    write_register(CFG_WINDOW_LENGTH, 7'd1);
    repeat (2) send_request(make_request(1));
    wait_idle();
    write_register(CFG_WINDOW_LENGTH, 7'd0);
    repeat (2) send_request(make_request(0));
    wait_idle();
    write_register(CFG_WINDOW_LENGTH, 7'd127);
    repeat (2) send_request(make_request(2));
    wait_idle();
    write_register(CFG_WINDOW_LENGTH, 7'd2);
    repeat (3) send_request({32'hFFFF_FFFF, {5{16'hFFFF}}});

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      enable = ($urandom_range(0, 6) != 0);
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0: win = 0;
          1: win = 1;
          2: win = 2;
          3: win = 64;
          4: win = $urandom_range(65, 127);
          5: win = 63;
          default: win = $urandom_range(1, 16);
        endcase
        write_register(CFG_WINDOW_LENGTH, CFG_DATA_W'(win));
      end else begin
        win = sb.wlen;
      end
      write_register(CFG_FILTER_ENABLE, {6'($urandom()), enable});
      if (win == 0) win = 1;
      if (win > 64) win = 64;
      count = $urandom_range(5, (3 * win + 10 > 200) ? 200 : 3 * win + 10);
      // the phase that carries the long hold-off needs enough requests behind it
      if (sent >= 300 && !hold_req && count < 20) count = 20;
      style = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) begin
        if (sent >= 300 && i == 3 && count >= 20) hold_req = 1'b1;
        send_request(make_request(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : style));
        sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_means.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/fcma_pkg.sv
sv/fcma_front.sv
sv/fcma_back.sv
sv/five_channel_moving_average.sv
verif/tb_top.sv
